// ----- hw/rtl/att_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and control/status types of the ack transaction table.
package att_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [15:0] ID_LIMIT = 16'd65535;

    // command codes
    localparam logic [2:0] CMD_CREATE     = 3'd0;
    localparam logic [2:0] CMD_FIND_ID    = 3'd1;
    localparam logic [2:0] CMD_FIND_KEY   = 3'd2;
    localparam logic [2:0] CMD_DELETE_ID  = 3'd3;
    localparam logic [2:0] CMD_DELETE_KEY = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    // error codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_NOT_FOUND = 2'd1;
    localparam logic [1:0] ERR_FULL      = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_en;
        logic apply;
    } att_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic scan_done;
    } att_sts_t;

endpackage

// ----- hw/rtl/att_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the ack transaction table.
interface att_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  msg_cmd;
    logic [7:0]  from_addr;
    logic [7:0]  to_addr;
    logic [15:0] trans_id;
    logic [31:0] now_ms;

    modport source (
        output valid, command, msg_cmd, from_addr, to_addr, trans_id, now_ms,
        input  ready
    );
    modport sink (
        input  valid, command, msg_cmd, from_addr, to_addr, trans_id, now_ms,
        output ready
    );
endinterface

interface att_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [1:0]  error_code;
    logic        entry_status;
    logic [15:0] trans_id_out;
    logic [31:0] entry_time;
    logic [7:0]  entry_cmd;
    logic [7:0]  entry_from;
    logic [7:0]  entry_to;
    logic [4:0]  entry_count;

    modport source (
        output valid, found, error_code, entry_status, trans_id_out, entry_time,
               entry_cmd, entry_from, entry_to, entry_count,
        input  ready
    );
    modport sink (
        input  valid, found, error_code, entry_status, trans_id_out, entry_time,
               entry_cmd, entry_from, entry_to, entry_count,
        output ready
    );
endinterface

// ----- hw/rtl/att_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: accept, scan the table, apply and hand off the result.
module att_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  att_pkg::att_sts_t  sts,
    output att_pkg::att_ctl_t  ctl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ctl.capture = 1'b0;
        ctl.scan_en = 1'b0;
        ctl.apply   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = sts.needs_scan ? ST_SCAN : ST_APPLY;
                end
            end
            ST_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                // table update and result load happen together, once the output slot frees
                if (out_free)
                begin
                    ctl.apply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.apply)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- hw/rtl/att_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: slot storage, sequential scan, id counter, entry count and result register.
module att_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  att_pkg::att_ctl_t  ctl,
    output att_pkg::att_sts_t  sts,
    input  logic [2:0]         command,
    input  logic [7:0]         msg_cmd,
    input  logic [7:0]         from_addr,
    input  logic [7:0]         to_addr,
    input  logic [15:0]        trans_id,
    input  logic [31:0]        now_ms,
    output logic               found,
    output logic [1:0]         error_code,
    output logic               entry_status,
    output logic [15:0]        trans_id_out,
    output logic [31:0]        entry_time,
    output logic [7:0]         entry_cmd,
    output logic [7:0]         entry_from,
    output logic [7:0]         entry_to,
    output logic [4:0]         entry_count
);

    localparam int N     = att_pkg::TABLE_ENTRIES;
    localparam int IDX_W = att_pkg::IDX_W;
    localparam int CNT_W = att_pkg::CNT_W;

    // slot storage, read and written at idx_reg only
    logic [7:0]  slot_cmd_reg    [N];
    logic [7:0]  slot_from_reg   [N];
    logic [7:0]  slot_to_reg     [N];
    logic [15:0] slot_id_reg     [N];
    logic        slot_status_reg [N];
    logic [31:0] slot_time_reg   [N];
    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;

    // captured request
    logic [2:0]  cmd_reg;
    logic [7:0]  key_cmd_reg;
    logic [7:0]  key_from_reg;
    logic [7:0]  key_to_reg;
    logic [15:0] id_reg;
    logic [31:0] now_reg;

    // scan state
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;
    logic             free_found_reg;
    logic             free_found_next;
    logic             hit_reg;
    logic             hit_next;
    logic             have_free_reg;
    logic             have_free_next;

    logic [15:0]      id_counter_reg;
    logic [15:0]      id_counter_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic        found_reg;
    logic [1:0]  err_reg;
    logic        status_reg;
    logic [15:0] tid_reg;
    logic [31:0] time_reg;
    logic [7:0]  ecmd_reg;
    logic [7:0]  efrom_reg;
    logic [7:0]  eto_reg;
    logic [4:0]  ecount_reg;

    logic        res_found;
    logic [1:0]  res_err;
    logic        res_status;
    logic [15:0] res_tid;
    logic [31:0] res_time;
    logic [7:0]  res_cmd;
    logic [7:0]  res_from;
    logic [7:0]  res_to;
    logic [4:0]  res_count;
    logic [31:0] count_wide;

    logic        by_id;
    logic        key_eq;
    logic        match;
    logic        is_last;
    logic        slot_free;
    logic        wr_en;
    logic [15:0] new_id;

    assign by_id   = (cmd_reg == att_pkg::CMD_FIND_ID) || (cmd_reg == att_pkg::CMD_DELETE_ID);
    assign key_eq  = (slot_cmd_reg[idx_reg] == key_cmd_reg)
                  && (slot_from_reg[idx_reg] == key_from_reg)
                  && (slot_to_reg[idx_reg] == key_to_reg);
    assign match   = valid_reg[idx_reg] && (by_id ? (slot_id_reg[idx_reg] == id_reg) : key_eq);
    assign is_last = (idx_reg == IDX_W'(N - 1));
    assign slot_free = !valid_reg[idx_reg];

    assign sts.needs_scan = (command == att_pkg::CMD_CREATE)
                         || (command == att_pkg::CMD_FIND_ID)
                         || (command == att_pkg::CMD_FIND_KEY)
                         || (command == att_pkg::CMD_DELETE_ID)
                         || (command == att_pkg::CMD_DELETE_KEY);
    assign sts.scan_done  = match || is_last;

    assign new_id = (id_counter_reg >= att_pkg::ID_LIMIT) ? 16'd1 : (id_counter_reg + 16'd1);

    // scan sequencing
    always_comb
    begin
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        hit_next        = hit_reg;
        have_free_next  = have_free_reg;
        if (ctl.capture)
        begin
            idx_next        = '0;
            free_found_next = 1'b0;
            hit_next        = 1'b0;
            have_free_next  = 1'b0;
        end
        else if (ctl.scan_en)
        begin
            if (slot_free && !free_found_reg)
            begin
                free_idx_next   = idx_reg;
                free_found_next = 1'b1;
            end
            if (match)
            begin
                hit_next = 1'b1;
            end
            else if (is_last)
            begin
                // no match: park on the lowest free slot for a create
                idx_next       = free_found_reg ? free_idx_reg : idx_reg;
                have_free_next = free_found_reg || slot_free;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // apply step: table update and result
    always_comb
    begin
        valid_next      = valid_reg;
        count_next      = count_reg;
        id_counter_next = id_counter_reg;
        wr_en           = 1'b0;
        res_found       = 1'b0;
        res_err         = att_pkg::ERR_OK;
        res_status      = 1'b0;
        res_tid         = '0;
        res_time        = '0;
        res_cmd         = '0;
        res_from        = '0;
        res_to          = '0;
        case (cmd_reg)
            att_pkg::CMD_CREATE:
            begin
                if (hit_reg || have_free_reg)
                begin
                    wr_en           = 1'b1;
                    id_counter_next = new_id;
                    valid_next[idx_reg] = 1'b1;
                    if (!hit_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    res_found  = 1'b1;
                    res_status = hit_reg;
                    res_tid    = new_id;
                    res_time   = now_reg;
                    res_cmd    = key_cmd_reg;
                    res_from   = key_from_reg;
                    res_to     = key_to_reg;
                end
                else
                begin
                    res_err = att_pkg::ERR_FULL;
                end
            end
            att_pkg::CMD_FIND_ID, att_pkg::CMD_FIND_KEY,
            att_pkg::CMD_DELETE_ID, att_pkg::CMD_DELETE_KEY:
            begin
                if (hit_reg)
                begin
                    res_found  = 1'b1;
                    res_status = slot_status_reg[idx_reg];
                    res_tid    = slot_id_reg[idx_reg];
                    res_time   = slot_time_reg[idx_reg];
                    res_cmd    = slot_cmd_reg[idx_reg];
                    res_from   = slot_from_reg[idx_reg];
                    res_to     = slot_to_reg[idx_reg];
                    if ((cmd_reg == att_pkg::CMD_DELETE_ID)
                        || (cmd_reg == att_pkg::CMD_DELETE_KEY))
                    begin
                        valid_next[idx_reg] = 1'b0;
                        count_next          = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    res_err = att_pkg::ERR_NOT_FOUND;
                end
            end
            att_pkg::CMD_CLEAR:
            begin
                valid_next = '0;
                count_next = '0;
            end
            default:
            begin
                res_err = att_pkg::ERR_OK;
            end
        endcase
        count_wide = 32'(count_next);
        res_count  = (count_wide > 32'd31) ? 5'd31 : count_wide[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            id_counter_reg <= '0;
            idx_reg        <= '0;
            free_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            have_free_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            free_idx_reg   <= free_idx_next;
            free_found_reg <= free_found_next;
            hit_reg        <= hit_next;
            have_free_reg  <= have_free_next;
            if (ctl.apply)
            begin
                valid_reg      <= valid_next;
                count_reg      <= count_next;
                id_counter_reg <= id_counter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg      <= command;
            key_cmd_reg  <= msg_cmd;
            key_from_reg <= from_addr;
            key_to_reg   <= to_addr;
            id_reg       <= trans_id;
            now_reg      <= now_ms;
        end
        if (ctl.apply && wr_en)
        begin
            slot_cmd_reg[idx_reg]    <= key_cmd_reg;
            slot_from_reg[idx_reg]   <= key_from_reg;
            slot_to_reg[idx_reg]     <= key_to_reg;
            slot_id_reg[idx_reg]     <= new_id;
            slot_status_reg[idx_reg] <= hit_reg;
            slot_time_reg[idx_reg]   <= now_reg;
        end
        if (ctl.apply)
        begin
            found_reg  <= res_found;
            err_reg    <= res_err;
            status_reg <= res_status;
            tid_reg    <= res_tid;
            time_reg   <= res_time;
            ecmd_reg   <= res_cmd;
            efrom_reg  <= res_from;
            eto_reg    <= res_to;
            ecount_reg <= res_count;
        end
    end

    assign found        = found_reg;
    assign error_code   = err_reg;
    assign entry_status = status_reg;
    assign trans_id_out = tid_reg;
    assign entry_time   = time_reg;
    assign entry_cmd    = ecmd_reg;
    assign entry_from   = efrom_reg;
    assign entry_to     = eto_reg;
    assign entry_count  = ecount_reg;

endmodule

// ----- hw/rtl/ack_transaction_table_unit.sv -----
`timescale 1ns / 1ps
// Ack transaction table: 16-slot keyed table of pending acknowledge transactions.
//
// req channel (sink): one transfer carries a command (create-or-use, find by id,
// find by key, delete by id, delete by key, clear all) with key, id and time.
// rsp channel (source): exactly one transfer per request, in request order.
//
// Timing: a request is taken in the idle cycle, then the table is scanned one
// slot per cycle until the lowest matching slot or the last slot, then the
// apply step updates the table and loads the response register. Clear all and
// unused commands skip the scan. A new request is accepted only in idle.
// Response appears the cycle after the apply step.
//
// Reset clears all valid marks, the entry count and the id counter; slot
// contents are not cleared and need no clearing pass.
// A stalled rsp channel holds the response; the next request is still accepted
// and scanned, and waits in the apply step until the response register frees.
module ack_transaction_table_unit (
    input  logic          clk,
    input  logic          rst_n,
    att_req_if.sink       req,
    att_rsp_if.source     rsp
);

    att_pkg::att_ctl_t ctl;
    att_pkg::att_sts_t sts;

    att_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    att_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .command      (req.command),
        .msg_cmd      (req.msg_cmd),
        .from_addr    (req.from_addr),
        .to_addr      (req.to_addr),
        .trans_id     (req.trans_id),
        .now_ms       (req.now_ms),
        .found        (rsp.found),
        .error_code   (rsp.error_code),
        .entry_status (rsp.entry_status),
        .trans_id_out (rsp.trans_id_out),
        .entry_time   (rsp.entry_time),
        .entry_cmd    (rsp.entry_cmd),
        .entry_from   (rsp.entry_from),
        .entry_to     (rsp.entry_to),
        .entry_count  (rsp.entry_count)
    );

endmodule
